>>> sv/os_match_timer_assert.svh
// assertion macros for the os match timer
// used by the modules that carry concurrent checks; no other dependencies
`ifndef OS_MATCH_TIMER_ASSERT_SVH
`define OS_MATCH_TIMER_ASSERT_SVH

// consequent must hold in the same cycle
`define OMT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("os match timer check failed");

// consequent must hold in the next cycle
`define OMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("os match timer check failed");

`endif

>>> sv/omt_pkg.sv
// shared types and constants of the os match timer
// no dependencies
`default_nettype none

package omt_pkg;

   localparam int DEF_NUM_MATCH  = 4;
   localparam int DEF_COUNT_BITS = 32;

   localparam int KIND_W = 2;
   localparam int IDX_W  = 3;
   localparam int DATA_W = 32;
   localparam int IRQ_W  = 4;

   localparam int REQ_FIELD_W = IDX_W + DATA_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = DATA_W + IRQ_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [IDX_W-1:0]  reg_index;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [IRQ_W-1:0]  irq_lines;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/omt_in_reg.sv
// input register of the os match timer: holds one request transfer
// depends on omt_pkg
`default_nettype none

module omt_in_reg (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [omt_pkg::REQ_TDATA_W-1:0] req_tdata,  // reg_index, write_data, zero pad
   input  wire logic [omt_pkg::KIND_W-1:0]      req_tuser,  // kind
   input  wire logic                           advance,
   output logic                                fire,
   output omt_pkg::req_type                    req
);
   import omt_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;
   logic    take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign fire       = valid_ff && advance;
   assign valid_in   = take || (valid_ff && !advance);
   assign req        = req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff.kind       <= kind_type'(req_tuser);
         req_ff.reg_index  <= req_tdata[IDX_W-1:0];
         req_ff.write_data <= req_tdata[IDX_W+DATA_W-1:IDX_W];
      end
   end

endmodule

`default_nettype wire

>>> sv/omt_core.sv
// timer state: counter, match registers, status and enable, with the per-item update
// depends on omt_pkg and os_match_timer_assert.svh
`default_nettype none

module omt_core #(
   parameter int NUM_MATCH  = omt_pkg::DEF_NUM_MATCH,
   parameter int COUNT_BITS = omt_pkg::DEF_COUNT_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire omt_pkg::req_type req,
   output omt_pkg::rsp_type      rsp
);
   import omt_pkg::*;
   `include "os_match_timer_assert.svh"

   localparam int IdxCounter = NUM_MATCH;
   localparam int IdxStatus  = NUM_MATCH + 1;
   localparam int IdxEnable  = NUM_MATCH + 2;

   logic [COUNT_BITS-1:0] cnt_ff;
   logic [COUNT_BITS-1:0] cnt_in;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [COUNT_BITS-1:0] match_ff [NUM_MATCH];
   logic [COUNT_BITS-1:0] match_in [NUM_MATCH];
   logic [NUM_MATCH-1:0]  status_ff;
   logic [NUM_MATCH-1:0]  status_in;
   logic [NUM_MATCH-1:0]  enable_ff;
   logic [NUM_MATCH-1:0]  enable_in;
   logic [DATA_W-1:0]     rd_data;
   int                    idx;

   assign cnt_inc = cnt_ff + 1'b1;
   assign idx     = int'(req.reg_index);

   always_comb begin
      cnt_in    = cnt_ff;
      match_in  = match_ff;
      status_in = status_ff;
      enable_in = enable_ff;
      rd_data   = '0;
      case (req.kind)
         KIND_TICK: begin
            cnt_in = cnt_inc;
            for (int i = 0; i < NUM_MATCH; i++) begin
               if (match_ff[i] == cnt_inc) begin
                  status_in[i] = 1'b1;
               end
            end
         end
         KIND_READ: begin
            for (int i = 0; i < NUM_MATCH; i++) begin
               if (idx == i) begin
                  rd_data = DATA_W'(match_ff[i]);
               end
            end
            if (idx == IdxCounter) begin
               rd_data = DATA_W'(cnt_ff);
            end
            if (idx == IdxStatus) begin
               rd_data = DATA_W'(status_ff);
            end
            if (idx == IdxEnable) begin
               rd_data = DATA_W'(enable_ff);
            end
         end
         KIND_WRITE: begin
            for (int i = 0; i < NUM_MATCH; i++) begin
               if (idx == i) begin
                  match_in[i] = COUNT_BITS'(req.write_data);
               end
            end
            if (idx == IdxCounter) begin
               cnt_in = COUNT_BITS'(req.write_data);
            end
            if (idx == IdxStatus) begin
               status_in = status_ff & ~NUM_MATCH'(req.write_data);
            end
            if (idx == IdxEnable) begin
               enable_in = NUM_MATCH'(req.write_data);
            end
         end
         default: begin
            rd_data = '0;
         end
      endcase
   end

   assign rsp.read_data = rd_data;
   assign rsp.irq_lines = IRQ_W'(status_in & enable_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         status_ff <= '0;
         enable_ff <= '0;
         for (int i = 0; i < NUM_MATCH; i++) begin
            match_ff[i] <= '0;
         end
      end else if (fire) begin
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
         enable_ff <= enable_in;
         match_ff  <= match_in;
      end
   end

   // counter only moves when a transfer is processed
   `OMT_ASSERT_NEXT(a_cnt_hold, clock, reset, !fire, $stable(cnt_ff))
   // a tick advances the counter by one, wrapping
   `OMT_ASSERT_NEXT(a_tick_inc, clock, reset, fire && req.kind == KIND_TICK, cnt_ff == $past(cnt_ff) + 1'b1)
   // status bits are only ever raised by a tick
   `OMT_ASSERT_NEXT(a_status_raise, clock, reset, !(fire && req.kind == KIND_TICK), (status_ff & ~$past(status_ff)) == '0)
   // only reads carry data
   `OMT_ASSERT_SAME(a_rd_zero, clock, reset, fire && req.kind != KIND_READ, rsp.read_data == '0)

endmodule

`default_nettype wire

>>> sv/omt_out_reg.sv
// result register of the os match timer: holds one response transfer
// depends on omt_pkg
`default_nettype none

module omt_out_reg (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           fire,
   input  wire omt_pkg::rsp_type               rsp,
   output logic                                advance,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [omt_pkg::RSP_TDATA_W-1:0]     rsp_tdata   // read_data, irq_lines, zero pad
);
   import omt_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   assign advance    = !valid_ff || rsp_tready;
   assign valid_in   = fire || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_ff.irq_lines, rsp_ff.read_data});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp;
      end
   end

endmodule

`default_nettype wire

>>> sv/os_match_timer.sv
// Operating-system timer with a free-running counter and match registers. Each request
// transfer is a tick, a register read or a register write (kind in tuser) and yields exactly
// one response transfer carrying read data (zero unless a read) and the interrupt lines,
// status AND enable, as they stand after that request. One request is taken every clock
// cycle unless a stalled response holds it back; a request is held in the input register,
// updates the timer state as it moves on, and its response appears from the result register
// in the cycle after that. Throughput is set by the single update path from input to
// result register: one increment and NUM_MATCH equality compares per cycle.
// depends on omt_pkg, omt_in_reg, omt_core, omt_out_reg
`default_nettype none

module os_match_timer #(
   parameter int NUM_MATCH  = omt_pkg::DEF_NUM_MATCH,
   parameter int COUNT_BITS = omt_pkg::DEF_COUNT_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [omt_pkg::REQ_TDATA_W-1:0] req_tdata,  // reg_index, write_data, zero pad
   input  wire logic [omt_pkg::KIND_W-1:0]      req_tuser,  // kind
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [omt_pkg::RSP_TDATA_W-1:0]      rsp_tdata   // read_data, irq_lines, zero pad
);
   import omt_pkg::*;

   logic    advance;
   logic    fire;
   req_type req;
   rsp_type rsp;

   omt_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .fire       (fire),
      .req        (req)
   );

   omt_core #(
      .NUM_MATCH  (NUM_MATCH),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req),
      .rsp   (rsp)
   );

   omt_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .rsp        (rsp),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> tb/omt_tb_pkg.sv
`timescale 1ns / 100ps
// register indexes and the spare kind code shared by the timer testbench files
// depends on omt_pkg
package omt_tb_pkg;

   localparam logic [omt_pkg::IDX_W-1:0] REG_MATCH0  = 3'd0;
   localparam logic [omt_pkg::IDX_W-1:0] REG_COUNTER = 3'd4;
   localparam logic [omt_pkg::IDX_W-1:0] REG_STATUS  = 3'd5;
   localparam logic [omt_pkg::IDX_W-1:0] REG_ENABLE  = 3'd6;
   localparam logic [omt_pkg::IDX_W-1:0] REG_SPARE   = 3'd7;

   localparam logic [omt_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

endpackage

>>> tb/os_match_timer_checker.sv
`timescale 1ns / 100ps
// checker for the os match timer: mirrors the timer registers on every request transfer,
// queues the expected response and compares each response transfer field by field
// depends on omt_pkg and omt_tb_pkg
module os_match_timer_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [omt_pkg::REQ_TDATA_W-1:0] req_tdata,  // reg_index, write_data, zero pad
   input  logic [omt_pkg::KIND_W-1:0]      req_tuser,  // kind
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [omt_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // read_data, irq_lines, zero pad
   output int                              fail_count,
   output int                              pending
);
   import omt_pkg::*;
   import omt_tb_pkg::*;

   localparam int NUM_MATCH = DEF_NUM_MATCH;

   logic [DATA_W-1:0] tmr_count;
   logic [DATA_W-1:0] tmr_match [NUM_MATCH];
   logic [IRQ_W-1:0]  tmr_status;
   logic [IRQ_W-1:0]  tmr_enable;
   rsp_type           expected_rsp [$];
   int                mismatches;

   task automatic timer_apply(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] wdata, output rsp_type result);
      logic [DATA_W-1:0] rd;
      rd = '0;
      case (kind)
         KIND_TICK: begin
            tmr_count = tmr_count + 1'b1;
            for (int i = 0; i < NUM_MATCH; i++)
               if (tmr_match[i] == tmr_count) tmr_status[i] = 1'b1;
         end
         KIND_READ: begin
            if (idx < NUM_MATCH) rd = tmr_match[idx];
            else if (idx == REG_COUNTER) rd = tmr_count;
            else if (idx == REG_STATUS) rd = DATA_W'(tmr_status);
            else if (idx == REG_ENABLE) rd = DATA_W'(tmr_enable);
         end
         KIND_WRITE: begin
            if (idx < NUM_MATCH) tmr_match[idx] = wdata;
            else if (idx == REG_COUNTER) tmr_count = wdata;
            else if (idx == REG_STATUS) tmr_status = tmr_status & ~wdata[IRQ_W-1:0];
            else if (idx == REG_ENABLE) tmr_enable = wdata[IRQ_W-1:0];
         end
         default: ;
      endcase
      result.read_data = rd;
      result.irq_lines = tmr_status & tmr_enable;
   endtask

   always @(posedge clock) begin
      rsp_type           want;
      logic [DATA_W-1:0] got_rd;
      logic [IRQ_W-1:0]  got_irq;
      if (reset) begin
         tmr_count = '0;
         for (int i = 0; i < NUM_MATCH; i++) tmr_match[i] = '0;
         tmr_status = '0;
         tmr_enable = '0;
         expected_rsp.delete();
         mismatches = 0;
      end else begin
         // responses first: one taken at this edge belongs to an earlier request
         if (rsp_tvalid && rsp_tready) begin
            got_rd  = rsp_tdata[DATA_W-1:0];
            got_irq = rsp_tdata[DATA_W +: IRQ_W];
            if (expected_rsp.size() == 0) begin
               mismatches++;
               $display("%0t unexpected response: expected none, actual rd %h irq %h",
                        $time, got_rd, got_irq);
            end else begin
               want = expected_rsp.pop_front();
               if (got_rd !== want.read_data) begin
                  mismatches++;
                  $display("%0t read_data mismatch: expected %h, actual %h",
                           $time, want.read_data, got_rd);
               end
               if (got_irq !== want.irq_lines) begin
                  mismatches++;
                  $display("%0t irq_lines mismatch: expected %h, actual %h",
                           $time, want.irq_lines, got_irq);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            timer_apply(req_tuser, req_tdata[IDX_W-1:0], req_tdata[IDX_W +: DATA_W], want);
            expected_rsp.push_back(want);
         end
      end
      fail_count <= mismatches;
      pending    <= expected_rsp.size();
   end

endmodule

>>> tb/os_match_timer_tb.sv
`timescale 1ns / 100ps
// top of the os match timer testbench: clock, reset, request and response stimulus, verdict
// depends on omt_pkg, omt_tb_pkg, os_match_timer_checker and the os_match_timer rtl
module os_match_timer_tb;
   import omt_pkg::*;
   import omt_tb_pkg::*;

   localparam int LONG_STALL = 300;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   int                     fail_count;
   int                     pending;

   int req_idle_mode = 1;
   int rsp_idle_mode = 1;
   int rsp_hold_req  = 0;
   int items_sent    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   os_match_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   os_match_timer_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 0 no idling, 1 occasional gaps, 2 a random gap, possibly none, before every transfer
   function automatic int idle_cycles(int mode);
      if (mode == 0) return 0;
      if (mode == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      return $urandom_range(0, 11);
   endfunction

   task automatic issue(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                        input logic [DATA_W-1:0] wdata);
      int gap;
      gap = idle_cycles(req_idle_mode);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_TDATA_W - REQ_FIELD_W){1'b0}}, wdata, idx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin : receiver
      int gap;
      int holds_done;
      holds_done = 0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req > holds_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            holds_done++;
         end
         gap = idle_cycles(rsp_idle_mode);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      logic [DATA_W-1:0] base;
      int                ahead;
      int                sel;
      int                phase_end;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, wrap, multiple matches, status clearing, ignored items
      for (int r = REG_MATCH0; r <= REG_SPARE; r++) issue(KIND_READ, IDX_W'(r), 32'hffff_ffff);
      issue(KIND_WRITE, REG_ENABLE, 32'hffff_ffff);
      issue(KIND_WRITE, REG_MATCH0, 32'h0000_0001);
      issue(KIND_TICK, REG_MATCH0, 32'h0);
      issue(KIND_WRITE, REG_COUNTER, 32'hffff_ffff);
      issue(KIND_TICK, REG_SPARE, 32'hffff_ffff);
      issue(KIND_TICK, REG_COUNTER, 32'h0);
      issue(KIND_READ, REG_STATUS, 32'h0);
      issue(KIND_WRITE, REG_STATUS, 32'h0000_0005);
      issue(KIND_READ, REG_STATUS, 32'h0);
      issue(KIND_WRITE, REG_STATUS, 32'h0);
      issue(KIND_WRITE, REG_SPARE, 32'hffff_ffff);
      issue(KIND_SPARE, REG_COUNTER, 32'hffff_ffff);
      issue(KIND_WRITE, REG_MATCH0 + 3'd2, 32'hffff_ffff);
      issue(KIND_WRITE, REG_COUNTER, 32'hffff_fffe);
      issue(KIND_TICK, REG_MATCH0, 32'h0);
      issue(KIND_READ, REG_MATCH0 + 3'd2, 32'h0);
      issue(KIND_WRITE, REG_ENABLE, 32'h0);
      issue(KIND_READ, REG_ENABLE, 32'h0);
      issue(KIND_WRITE, REG_STATUS, 32'hffff_ffff);
      issue(KIND_READ, REG_COUNTER, 32'h0);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         req_idle_mode = (phase == 0) ? 0 : $urandom_range(0, 2);
         rsp_idle_mode = (phase == 0) ? 0 : $urandom_range(0, 2);
         if (phase == 3) begin
            // long receiver stall while requests keep coming
            req_idle_mode = 0;
            rsp_hold_req++;
         end
         phase_end = items_sent + 140;
         while (items_sent < phase_end) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  // arm a match a few ticks ahead, tick to just short of, onto or past it, then inspect and clear
                  base  = ($urandom_range(0, 3) == 0) ? 32'hffff_fff8 + $urandom_range(0, 7)
                                                      : $urandom;
                  ahead = $urandom_range(1, 6);
                  sel   = $urandom_range(0, DEF_NUM_MATCH - 1);
                  issue(KIND_WRITE, REG_COUNTER, base);
                  issue(KIND_WRITE, REG_MATCH0 + IDX_W'(sel), base + DATA_W'(ahead));
                  if ($urandom_range(0, 1))
                     issue(KIND_WRITE,
                           REG_MATCH0 + IDX_W'($urandom_range(0, DEF_NUM_MATCH - 1)),
                           base + $urandom_range(1, 6));
                  issue(KIND_WRITE, REG_ENABLE, $urandom);
                  repeat ($urandom_range(ahead - 1, ahead + 2))
                     issue(KIND_TICK, IDX_W'($urandom), $urandom);
                  issue(KIND_READ, REG_STATUS, $urandom);
                  if ($urandom_range(0, 1)) issue(KIND_READ, REG_COUNTER, $urandom);
                  issue(KIND_WRITE, REG_STATUS, $urandom_range(0, 1) ? 32'hffff_ffff : $urandom);
               end
               6, 7, 8: begin
                  issue(KIND_W'($urandom_range(KIND_TICK, KIND_SPARE)),
                        IDX_W'($urandom_range(REG_MATCH0, REG_SPARE)),
                        $urandom);
               end
               default: begin
                  repeat ($urandom_range(1, 8)) issue(KIND_TICK, IDX_W'($urandom), $urandom);
                  issue(KIND_READ, IDX_W'($urandom_range(REG_MATCH0, REG_SPARE)), $urandom);
               end
            endcase
         end
         if (phase % 2 == 1) wait_drained();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
